FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants of the generational handle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ght_pkg;

	localparam int CAPACITY_DEF     = 64;
	localparam int INDEX_BITS_DEF   = 16;
	localparam int GEN_LIMIT_DEF    = 65535;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int FIELD_W = 32;
	localparam int GEN_W   = 16;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_RESULT
	} state_t;

	// Free-map update for one slot: take marks it used, give marks it usable again.
	typedef struct packed {
		logic take;
		logic give;
	} map_upd_t;

endpackage

FILE: rtl/core/generational_handle_table_core.sv
// ----------------------------------------------------------------------------
// generational_handle_table_core
// Slot table mapping generation-tagged handles to nonzero payloads.
// ----------------------------------------------------------------------------
// One transaction at a time: a request is accepted in the idle state, and the
// accepting edge also launches the read of its slot from the synchronous slot
// memory. The lookup state checks the generation, writes the slot back and
// updates the free map and live count, and the result state then loads the
// result into the output register once out_stall allows. A new transaction is
// accepted only after the result is loaded, since the write-back must land
// before the next lookup. in_stall is high while a transaction is in flight.
// Reset clears all slots at once through per-slot valid bits and the free
// bitmap; no clearing pass is needed. Inserts take the lowest free slot whose
// generation is below GENERATION_LIMIT; a slot that reaches the limit on
// remove is retired for good.
`timescale 1ns / 1ps

module generational_handle_table_core #(
	parameter int CAPACITY         = ght_pkg::CAPACITY_DEF,
	parameter int INDEX_BITS       = ght_pkg::INDEX_BITS_DEF,
	parameter int GENERATION_LIMIT = ght_pkg::GEN_LIMIT_DEF,
	parameter int PAYLOAD_BITS     = ght_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [ght_pkg::FIELD_W-1:0]   handle_in,
	input  logic [ght_pkg::FIELD_W-1:0]   payload_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ght_pkg::FIELD_W-1:0]   handle_out,
	output logic [ght_pkg::FIELD_W-1:0]   payload_out,
	output logic                          ok,
	output logic [ght_pkg::COUNT_W-1:0]   live_count
);

	localparam int IDX_MAX = (1 << INDEX_BITS) - 1;
	localparam int DEPTH   = (CAPACITY < IDX_MAX) ? CAPACITY : IDX_MAX;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW      = (PAYLOAD_BITS < ght_pkg::FIELD_W) ? PAYLOAD_BITS
	                                                          : ght_pkg::FIELD_W;
	localparam int CW      = $clog2(DEPTH + 1);
	localparam logic [ght_pkg::GEN_W-1:0] GEN_MAX = ght_pkg::GEN_W'(GENERATION_LIMIT);

	ght_pkg::state_t state_q, state_d;

	// Request registers
	ght_pkg::op_t              op_q;
	logic [ght_pkg::FIELD_W-1:0] handle_q;
	logic [PW-1:0]             pay_q;
	logic [AW-1:0]             addr_q;
	logic                      pre_ok_q;

	// Result registers
	logic [ght_pkg::FIELD_W-1:0] res_handle_q, res_payload_q;
	logic                      res_ok_q;
	logic [CW-1:0]             res_cnt_q;
	logic [CW-1:0]             cnt_q;

	// Output register
	logic                      out_valid_q;
	logic [ght_pkg::FIELD_W-1:0] out_handle_q, out_payload_q;
	logic                      out_ok_q;
	logic [CW-1:0]             out_cnt_q;
	logic [ght_pkg::FIELD_W-1:0] live_ext;

	// Decode
	ght_pkg::op_t              op_in;
	logic [ght_pkg::FIELD_W-1:0] idx_ext, hgen_in;
	logic [PW-1:0]             pay_in;
	logic [AW-1:0]             lookup_addr, mem_addr;
	logic                      pre_ok;

	// Lookup stage
	logic                      found;
	logic [AW-1:0]             first_addr;
	logic [PW-1:0]             rd_payload;
	logic [ght_pkg::GEN_W-1:0] rd_gen;
	logic                      gen_match, hit;
	logic [ght_pkg::GEN_W-1:0] ins_gen, rem_gen, wr_gen;
	logic [PW-1:0]             wr_payload;
	logic [63:0]               handle_wide;
	logic [ght_pkg::FIELD_W-1:0] step_handle, step_payload;
	logic                      step_ok;
	logic [CW-1:0]             cnt_d;
	ght_pkg::map_upd_t         map_upd;

	// Control
	logic in_fire, rd_en, wr_en, lookup_en, out_load;

	assign op_in   = ght_pkg::op_t'(op);
	assign idx_ext = ght_pkg::FIELD_W'(handle_in[INDEX_BITS-1:0]);
	assign hgen_in = handle_in >> INDEX_BITS;
	assign pay_in  = payload_in[PW-1:0];

	always_comb begin
		lookup_addr = AW'(idx_ext - ght_pkg::FIELD_W'(1));
		pre_ok      = 1'b0;
		case (op_in)
			ght_pkg::OP_INSERT: begin
				lookup_addr = first_addr;
				pre_ok      = (pay_in != '0) && found;
			end
			ght_pkg::OP_GET, ght_pkg::OP_REMOVE: begin
				pre_ok = (idx_ext != '0) && (hgen_in != '0)
				      && (idx_ext <= ght_pkg::FIELD_W'(DEPTH));
			end
			default: pre_ok = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ght_pkg::ST_IDLE:   if (in_valid) state_d = ght_pkg::ST_LOOKUP;
			ght_pkg::ST_LOOKUP: state_d = ght_pkg::ST_RESULT;
			ght_pkg::ST_RESULT: if (!out_valid_q || !out_stall) state_d = ght_pkg::ST_IDLE;
			default:            state_d = ght_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_stall  = 1'b1;
		lookup_en = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ght_pkg::ST_IDLE:   in_stall  = 1'b0;
			ght_pkg::ST_LOOKUP: lookup_en = 1'b1;
			ght_pkg::ST_RESULT: out_load  = !out_valid_q || !out_stall;
			default:            in_stall  = 1'b1;
		endcase
	end

	assign in_fire  = in_valid && !in_stall;
	assign rd_en    = in_fire;
	assign mem_addr = lookup_en ? addr_q : lookup_addr;

	// Lookup: check generation, form result and write-back
	assign gen_match   = ght_pkg::FIELD_W'(rd_gen) == (handle_q >> INDEX_BITS);
	assign hit         = pre_ok_q && gen_match && (rd_payload != '0);
	assign ins_gen     = (rd_gen == '0) ? ght_pkg::GEN_W'(1) : rd_gen;
	assign rem_gen     = (rd_gen < GEN_MAX) ? rd_gen + ght_pkg::GEN_W'(1) : rd_gen;
	assign handle_wide = (64'(ins_gen) << INDEX_BITS) | (64'(addr_q) + 64'd1);

	always_comb begin
		step_handle  = '0;
		step_payload = '0;
		step_ok      = 1'b0;
		wr_en        = 1'b0;
		wr_payload   = pay_q;
		wr_gen       = ins_gen;
		map_upd      = '0;
		cnt_d        = cnt_q;
		case (op_q)
			ght_pkg::OP_INSERT: begin
				if (pre_ok_q) begin
					step_handle  = handle_wide[ght_pkg::FIELD_W-1:0];
					step_ok      = 1'b1;
					wr_en        = lookup_en;
					map_upd.take = lookup_en;
					cnt_d        = cnt_q + CW'(1);
				end
			end
			ght_pkg::OP_GET: begin
				if (hit) begin
					step_payload = ght_pkg::FIELD_W'(rd_payload);
					step_ok      = 1'b1;
				end
			end
			ght_pkg::OP_REMOVE: begin
				if (hit) begin
					step_payload = ght_pkg::FIELD_W'(rd_payload);
					step_ok      = 1'b1;
					wr_en        = lookup_en;
					wr_payload   = '0;
					wr_gen       = rem_gen;
					// Slot at the generation limit stays retired.
					map_upd.give = lookup_en && (rem_gen < GEN_MAX);
					cnt_d        = (cnt_q != '0) ? cnt_q - CW'(1) : cnt_q;
				end
			end
			default: step_ok = 1'b0;
		endcase
	end

	ght_store #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.PW    (PW)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.wr_en      (wr_en),
		.addr       (mem_addr),
		.wr_payload (wr_payload),
		.wr_gen     (wr_gen),
		.rd_payload (rd_payload),
		.rd_gen     (rd_gen)
	);

	ght_free_map #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_free_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (map_upd),
		.upd_addr   (addr_q),
		.found      (found),
		.first_addr (first_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ght_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (lookup_en)
				cnt_q <= cnt_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= op_in;
			handle_q <= handle_in;
			pay_q    <= pay_in;
			addr_q   <= lookup_addr;
			pre_ok_q <= pre_ok;
		end
		if (lookup_en) begin
			res_handle_q  <= step_handle;
			res_payload_q <= step_payload;
			res_ok_q      <= step_ok;
			res_cnt_q     <= cnt_d;
		end
		if (out_load) begin
			out_handle_q  <= res_handle_q;
			out_payload_q <= res_payload_q;
			out_ok_q      <= res_ok_q;
			out_cnt_q     <= res_cnt_q;
		end
	end

	assign live_ext    = ght_pkg::FIELD_W'(out_cnt_q);
	assign out_valid   = out_valid_q;
	assign handle_out  = out_handle_q;
	assign payload_out = out_payload_q;
	assign ok          = out_ok_q;
	assign live_count  = live_ext[ght_pkg::COUNT_W-1:0];

endmodule

FILE: rtl/core/ght_store.sv
// ----------------------------------------------------------------------------
// ght_store
// Slot memories (payload and generation) with one read-or-write port,
// registered read data and per-slot valid bits that reset clears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ght_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int PW    = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic                     wr_en,
	input  logic [AW-1:0]            addr,
	input  logic [PW-1:0]            wr_payload,
	input  logic [ght_pkg::GEN_W-1:0] wr_gen,
	output logic [PW-1:0]            rd_payload,
	output logic [ght_pkg::GEN_W-1:0] rd_gen
);

	logic [PW-1:0]             pay_mem [DEPTH];
	logic [ght_pkg::GEN_W-1:0] gen_mem [DEPTH];
	logic [DEPTH-1:0]          vld_q;
	logic                      rd_vld_q;
	logic [PW-1:0]             rd_pay_q;
	logic [ght_pkg::GEN_W-1:0] rd_gen_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pay_mem[addr] <= wr_payload;
			gen_mem[addr] <= wr_gen;
		end
		if (rd_en) begin
			rd_pay_q <= pay_mem[addr];
			rd_gen_q <= gen_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[addr];
		end
	end

	// Slot never written since reset reads as free with generation zero.
	assign rd_payload = rd_vld_q ? rd_pay_q : '0;
	assign rd_gen     = rd_vld_q ? rd_gen_q : '0;

endmodule

FILE: rtl/core/ght_free_map.sv
// ----------------------------------------------------------------------------
// ght_free_map
// Bitmap of usable slots (free and not retired) with a lowest-first
// priority encoder that picks the slot for the next insert.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ght_free_map #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ght_pkg::map_upd_t upd,
	input  logic [AW-1:0]     upd_addr,
	output logic              found,
	output logic [AW-1:0]     first_addr
);

	logic [DEPTH-1:0] usable_q;
	logic [DEPTH-1:0] lowest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= '1;
		end else begin
			if (upd.take)
				usable_q[upd_addr] <= 1'b0;
			else if (upd.give)
				usable_q[upd_addr] <= 1'b1;
		end
	end

	// Isolate the lowest set bit, then fold the one-hot vector into an index.
	assign lowest = usable_q & (~usable_q + DEPTH'(1));
	assign found  = |usable_q;

	always_comb begin
		first_addr = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lowest[i])
				first_addr = first_addr | AW'(i);
		end
	end

endmodule

FILE: rtl/core/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_checker
// Port-level checks of the handle table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ght_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  op,
	input logic [31:0] handle_in,
	input logic [31:0] payload_in,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] handle_out,
	input logic [31:0] payload_out,
	input logic        ok,
	input logic [6:0]  live_count
);

	`GHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(handle_out) && $stable(payload_out) && $stable(ok) && $stable(live_count), "stalled result transaction changed")
	`GHT_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second transaction accepted while one is in flight")
	`GHT_ASSERT_NOW(a_fail_zero, out_valid && !ok, handle_out == 32'd0 && payload_out == 32'd0, "failed transaction carries a handle or payload")
	`GHT_ASSERT_NOW(a_handle_ok, out_valid && handle_out != 32'd0, ok && payload_out == 32'd0, "insert handle without success or with payload")

endmodule

bind generational_handle_table_core ght_checker u_ght_checker (.*);
